@@ hdl/ray_capped_cylinder_hit_test_top_defines.svh @@
// Assertion macros for the capped-cylinder hit test block.
`ifndef RAY_CAPPED_CYLINDER_HIT_TEST_TOP_DEFINES_SVH
`define RAY_CAPPED_CYLINDER_HIT_TEST_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define RCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rcc_pkg.sv @@
// Shared types, constants and Q16.16 saturating arithmetic for the hit test.
`default_nettype none
package rcc_pkg;

  localparam logic signed [31:0] FX_ONE  = 32'sd65536;
  localparam logic signed [31:0] FX_MAX  = 32'sd2147483647;
  localparam logic signed [31:0] FX_MIN  = -32'sd2147483648;
  localparam logic signed [63:0] FX_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] FX_MIN64 = -64'sd2147483648;
  localparam logic signed [31:0] EPSILON = 32'sd66;

  localparam logic [3:0] CFG_CENTER_X = 4'd0;
  localparam logic [3:0] CFG_CENTER_Y = 4'd1;
  localparam logic [3:0] CFG_CENTER_Z = 4'd2;
  localparam logic [3:0] CFG_AXIS_X   = 4'd3;
  localparam logic [3:0] CFG_AXIS_Y   = 4'd4;
  localparam logic [3:0] CFG_AXIS_Z   = 4'd5;
  localparam logic [3:0] CFG_RADIUS2  = 4'd6;
  localparam logic [3:0] CFG_HALF_H   = 4'd7;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int SQ_ST   = 12;
  localparam int SQ_LAT  = SQ_ST + 1;
  localparam int DV_ST   = 24;
  localparam int DV_LAT  = DV_ST + 1;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
    logic [30:0]        r2;
    logic [30:0]        hh;
  } rcc_cfg_t;

  typedef struct packed {
    logic signed [31:0] dn;
    logic signed [31:0] con;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [30:0]        maxd;
  } rcc_item_t;

  typedef struct packed {
    rcc_item_t it;
    logic      surf;
  } rcc_bside_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rcc_fifo_st_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > FX_MAX64) r = FX_MAX;
    else if (x < FX_MIN64) r = FX_MIN;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] fadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] fsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [31:0] fneg(input logic signed [31:0] a);
    return sat32(-64'(a));
  endfunction

  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(p >>> 16);
  endfunction

endpackage
`default_nettype wire

@@ hdl/rcc_sqrt.sv @@
// Pipelined integer square root, two result bits per stage.
`default_nettype none
module rcc_sqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [30:0] x,
  output logic      [23:0] root
);
  import rcc_pkg::*;

  logic [47:0] rad_r  [0:SQ_ST];
  logic [27:0] rem_r  [0:SQ_ST];
  logic [23:0] root_r [0:SQ_ST];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= {1'b0, x, 16'b0};
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_ST; k++) begin : g_st
    logic [27:0] r1, t1, r1n, r2, t2, r2n;
    logic [23:0] q1, q2;

    always_comb begin
      r1 = {rem_r[k][25:0], rad_r[k][47:46]};
      t1 = {2'b0, root_r[k], 2'b01};
      if (r1 >= t1) begin
        r1n = r1 - t1;
        q1  = {root_r[k][22:0], 1'b1};
      end else begin
        r1n = r1;
        q1  = {root_r[k][22:0], 1'b0};
      end
      r2 = {r1n[25:0], rad_r[k][45:44]};
      t2 = {2'b0, q1, 2'b01};
      if (r2 >= t2) begin
        r2n = r2 - t2;
        q2  = {q1[22:0], 1'b1};
      end else begin
        r2n = r2;
        q2  = {q1[22:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= {rad_r[k][43:0], 4'b0};
        rem_r[k+1]  <= r2n;
        root_r[k+1] <= q2;
      end
    end
  end

  assign root = root_r[SQ_ST];
endmodule
`default_nettype wire

@@ hdl/rcc_div.sv @@
// Pipelined Q16.16 signed divider, two quotient bits per stage, saturating.
`default_nettype none
module rcc_div (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic signed      [31:0] quo
);
  import rcc_pkg::*;

  logic [47:0] acc_r [0:DV_ST];
  logic [31:0] rem_r [0:DV_ST];
  logic [31:0] dvs_r [0:DV_ST];
  logic        neg_r [0:DV_ST];
  logic signed [32:0] num_e, den_e;
  logic signed [63:0] qs;

  always_comb begin
    num_e = 33'(num);
    den_e = 33'(den);
    if (num_e < 0) num_e = -num_e;
    if (den_e < 0) den_e = -den_e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r[0] <= {num_e[31:0], 16'b0};
      rem_r[0] <= '0;
      dvs_r[0] <= den_e[31:0];
      neg_r[0] <= num[31] ^ den[31];
    end
  end

  for (genvar k = 0; k < DV_ST; k++) begin : g_st
    logic [32:0] r1, r1n, r2, r2n;
    logic        b1, b2;

    always_comb begin
      r1 = {rem_r[k], acc_r[k][47]};
      b1 = (r1 >= {1'b0, dvs_r[k]});
      r1n = b1 ? r1 - {1'b0, dvs_r[k]} : r1;
      r2 = {r1n[31:0], acc_r[k][46]};
      b2 = (r2 >= {1'b0, dvs_r[k]});
      r2n = b2 ? r2 - {1'b0, dvs_r[k]} : r2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k+1] <= {acc_r[k][45:0], b1, b2};
        rem_r[k+1] <= r2n[31:0];
        dvs_r[k+1] <= dvs_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  always_comb begin
    qs = $signed({16'b0, acc_r[DV_ST]});
    if (neg_r[DV_ST]) qs = -qs;
    quo = sat32(qs);
  end
endmodule
`default_nettype wire

@@ hdl/rcc_front.sv @@
// Front pipeline: accept rays and reduce them to the quadratic terms.
`default_nettype none
module rcc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rcc_pkg::rcc_cfg_t  cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_origin_x,
  input  wire logic signed [31:0] in_origin_y,
  input  wire logic signed [31:0] in_origin_z,
  input  wire logic signed [17:0] in_dir_x,
  input  wire logic signed [17:0] in_dir_y,
  input  wire logic signed [17:0] in_dir_z,
  input  wire logic        [30:0] in_max_distance,
  input  wire logic               q_full,
  output logic                    item_v,
  output rcc_pkg::rcc_item_t      item
);
  import rcc_pkg::*;

  logic [4:0] v_r;
  logic       adv;

  logic signed [31:0] co_r [3];
  logic signed [31:0] dir_r [3];
  logic [30:0]        maxd0_r, maxd1_r, maxd2_r, maxd3_r;
  logic signed [31:0] pdd_r [3];
  logic signed [31:0] pca_r [3];
  logic signed [31:0] pdc_r [3];
  logic signed [31:0] pcc_r [3];
  logic signed [31:0] dn2_r, con2_r, dc2_r, cc2_r;
  logic signed [31:0] dn3_r, con3_r, dc3_r, cc3_r, m_dd_r, m_dc_r, m_cc_r;
  logic signed [31:0] ax [3];

  assign adv      = !v_r[4] || !q_full;
  assign in_ready = adv;
  assign item_v   = v_r[4];
  assign ax[0]    = 32'(cfg.ax);
  assign ax[1]    = 32'(cfg.ay);
  assign ax[2]    = 32'(cfg.az);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      co_r[0]  <= fsub(in_origin_x, cfg.cx);
      co_r[1]  <= fsub(in_origin_y, cfg.cy);
      co_r[2]  <= fsub(in_origin_z, cfg.cz);
      dir_r[0] <= 32'(in_dir_x);
      dir_r[1] <= 32'(in_dir_y);
      dir_r[2] <= 32'(in_dir_z);
      maxd0_r  <= in_max_distance;

      for (int i = 0; i < 3; i++) begin
        pdd_r[i] <= fmul(dir_r[i], ax[i]);
        pca_r[i] <= fmul(co_r[i], ax[i]);
        pdc_r[i] <= fmul(dir_r[i], co_r[i]);
        pcc_r[i] <= fmul(co_r[i], co_r[i]);
      end
      maxd1_r <= maxd0_r;

      dn2_r   <= fadd(fadd(pdd_r[0], pdd_r[1]), pdd_r[2]);
      con2_r  <= fadd(fadd(pca_r[0], pca_r[1]), pca_r[2]);
      dc2_r   <= fadd(fadd(pdc_r[0], pdc_r[1]), pdc_r[2]);
      cc2_r   <= fadd(fadd(pcc_r[0], pcc_r[1]), pcc_r[2]);
      maxd2_r <= maxd1_r;

      m_dd_r  <= fmul(dn2_r, dn2_r);
      m_dc_r  <= fmul(dn2_r, con2_r);
      m_cc_r  <= fmul(con2_r, con2_r);
      dn3_r   <= dn2_r;
      con3_r  <= con2_r;
      dc3_r   <= dc2_r;
      cc3_r   <= cc2_r;
      maxd3_r <= maxd2_r;

      item.a    <= fsub(FX_ONE, m_dd_r);
      item.b    <= fsub(dc3_r, m_dc_r);
      item.c    <= fsub(cc3_r, m_cc_r);
      item.dn   <= dn3_r;
      item.con  <= con3_r;
      item.maxd <= maxd3_r;
    end
  end
endmodule
`default_nettype wire

@@ hdl/rcc_fifo.sv @@
// Short register queue between the front and back pipelines.
`default_nettype none
module rcc_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rcc_pkg::rcc_item_t push_d,
  input  wire logic          pop,
  output rcc_pkg::rcc_item_t head_d,
  output rcc_pkg::rcc_fifo_st_t st
);
  import rcc_pkg::*;

  rcc_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;

  assign st.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign st.empty = (cnt_r == '0);
  assign head_d   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_d;
  end
endmodule
`default_nettype wire

@@ hdl/rcc_back.sv @@
// Back pipeline: discriminant, root, divisions and range checks per ray.
`default_nettype none
module rcc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rcc_pkg::rcc_cfg_t  cfg,
  input  wire logic          head_v,
  input  wire rcc_pkg::rcc_item_t head_d,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_hit
);
  import rcc_pkg::*;

  logic adv;
  logic [2:0] vb_r;
  logic [SQ_LAT-1:0] sqv_r;
  logic [DV_LAT-1:0] dvv_r;
  logic vn_r;
  logic [2:0] vp_r;
  logic out_valid_r, out_hit_r;

  rcc_item_t it0_r, it1_r, it2_r;
  logic signed [31:0] bb0_r, cr0_r, bb1_r, mac1_r, disc2_r;
  rcc_bside_t sq_side_r [SQ_LAT];
  rcc_bside_t dv_side_r [DV_LAT];
  rcc_bside_t nside_r;
  logic signed [31:0] n0_r, n1_r, m0_r, m1_r;
  logic [23:0] root;
  logic signed [31:0] ts0, ts1, td0, td1;
  logic signed [31:0] sroot;
  logic signed [31:0] negb, negc, hh32, r2s;

  logic signed [31:0] mts0_r, mts1_r, at0_r, at1_r, bb2_r, td0_1_r, td1_1_r;
  logic rs0_r, rs1_r, rd0_r, rd1_r;
  rcc_bside_t p1side_r;
  logic signed [31:0] u0_r, u1_r, td0_2_r, td1_2_r, c2_r, c3_r;
  logic rd0_2_r, rd1_2_r, sh2_r, dok2_r, rd0_3_r, rd1_3_r, sh3_r, dok3_r;
  logic signed [31:0] w0_r, w1_r;
  logic signed [32:0] h0, h1, dne;
  logic hok0, hok1;
  logic signed [31:0] maxs;
  logic q0, q1;

  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && head_v;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign sroot     = 32'($signed({8'b0, root}));
  assign hh32      = $signed({1'b0, cfg.hh});
  assign r2s       = $signed({1'b0, cfg.r2});

  rcc_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .x    (disc2_r[31] ? 31'd0 : disc2_r[30:0]),
    .root (root)
  );

  rcc_div u_div_s0 (.clk(clk), .en(adv), .num(n0_r), .den(nside_r.it.a),  .quo(ts0));
  rcc_div u_div_s1 (.clk(clk), .en(adv), .num(n1_r), .den(nside_r.it.a),  .quo(ts1));
  rcc_div u_div_d0 (.clk(clk), .en(adv), .num(m0_r), .den(nside_r.it.dn), .quo(td0));
  rcc_div u_div_d1 (.clk(clk), .en(adv), .num(m1_r), .den(nside_r.it.dn), .quo(td1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= '0;
      sqv_r       <= '0;
      vn_r        <= 1'b0;
      dvv_r       <= '0;
      vp_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vb_r        <= {vb_r[1:0], head_v};
      sqv_r       <= {sqv_r[SQ_LAT-2:0], vb_r[2]};
      vn_r        <= sqv_r[SQ_LAT-1];
      dvv_r       <= {dvv_r[DV_LAT-2:0], vn_r};
      vp_r        <= {vp_r[1:0], dvv_r[DV_LAT-1]};
      out_valid_r <= vp_r[2];
    end
  end

  always_comb begin
    negb = fneg(sq_side_r[SQ_LAT-1].it.b);
    negc = fneg(sq_side_r[SQ_LAT-1].it.con);
    maxs = $signed({1'b0, dv_side_r[DV_LAT-1].it.maxd});
    h0   = 33'(fadd(p1side_r.it.con, mts0_r));
    h1   = 33'(fadd(p1side_r.it.con, mts1_r));
    if (h0 < 0) h0 = -h0;
    if (h1 < 0) h1 = -h1;
    hok0 = (h0 <= 33'(hh32));
    hok1 = (h1 <= 33'(hh32));
    dne  = 33'(p1side_r.it.dn);
    if (dne < 0) dne = -dne;
    q0   = (fadd(w0_r, c3_r) <= r2s);
    q1   = (fadd(w1_r, c3_r) <= r2s);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it0_r <= head_d;
      bb0_r <= fmul(head_d.b, head_d.b);
      cr0_r <= fsub(head_d.c, r2s);

      it1_r  <= it0_r;
      bb1_r  <= bb0_r;
      mac1_r <= fmul(it0_r.a, cr0_r);

      it2_r   <= it1_r;
      disc2_r <= fsub(bb1_r, mac1_r);

      sq_side_r[0].it   <= it2_r;
      sq_side_r[0].surf <= (it2_r.a >= EPSILON) && !disc2_r[31];
      for (int i = 1; i < SQ_LAT; i++) sq_side_r[i] <= sq_side_r[i-1];

      nside_r <= sq_side_r[SQ_LAT-1];
      n0_r    <= fsub(negb, sroot);
      n1_r    <= fadd(negb, sroot);
      m0_r    <= fsub(negc, hh32);
      m1_r    <= fadd(negc, hh32);

      dv_side_r[0] <= nside_r;
      for (int i = 1; i < DV_LAT; i++) dv_side_r[i] <= dv_side_r[i-1];

      p1side_r <= dv_side_r[DV_LAT-1];
      mts0_r   <= fmul(ts0, dv_side_r[DV_LAT-1].it.dn);
      mts1_r   <= fmul(ts1, dv_side_r[DV_LAT-1].it.dn);
      at0_r    <= fmul(dv_side_r[DV_LAT-1].it.a, td0);
      at1_r    <= fmul(dv_side_r[DV_LAT-1].it.a, td1);
      bb2_r    <= fadd(dv_side_r[DV_LAT-1].it.b, dv_side_r[DV_LAT-1].it.b);
      td0_1_r  <= td0;
      td1_1_r  <= td1;
      rs0_r    <= (ts0 > EPSILON) && (ts0 < maxs);
      rs1_r    <= (ts1 > EPSILON) && (ts1 < maxs);
      rd0_r    <= (td0 > EPSILON) && (td0 < maxs);
      rd1_r    <= (td1 > EPSILON) && (td1 < maxs);

      u0_r    <= fadd(at0_r, bb2_r);
      u1_r    <= fadd(at1_r, bb2_r);
      td0_2_r <= td0_1_r;
      td1_2_r <= td1_1_r;
      c2_r    <= p1side_r.it.c;
      rd0_2_r <= rd0_r;
      rd1_2_r <= rd1_r;
      sh2_r   <= p1side_r.surf && ((rs0_r && hok0) || (rs1_r && hok1));
      dok2_r  <= (dne >= 33'(EPSILON));

      w0_r    <= fmul(u0_r, td0_2_r);
      w1_r    <= fmul(u1_r, td1_2_r);
      c3_r    <= c2_r;
      rd0_3_r <= rd0_2_r;
      rd1_3_r <= rd1_2_r;
      sh3_r   <= sh2_r;
      dok3_r  <= dok2_r;

      out_hit_r <= sh3_r || (dok3_r && ((rd0_3_r && q0) || (rd1_3_r && q1)));
    end
  end
endmodule
`default_nettype wire

@@ hdl/ray_capped_cylinder_hit_test_top.sv @@
// Top level of the ray versus capped-cylinder hit test.
// Input channel (in_*): one ray per transfer, origin and unit direction in
// Q16.16 plus an exclusive distance bound. Result channel (out_*): one hit
// bit per ray, in arrival order. Configuration channel (cfg_*): register
// index and data, always ready; write it only while no ray is in flight.
// From the input transfer to out_valid a ray passes through 5 front
// stages, the queue, and 46 back stages, most of them in the square root
// and the dividers (two bits per stage). Throughput is one ray per cycle
// while nothing stalls. The back pipeline halts as a whole while
// out_valid is high and out_ready is low; the 4-entry queue then absorbs the
// front pipeline, which drops in_ready once the queue fills.
// Synchronous active-low reset empties both pipelines and the queue and
// restores the register defaults: center 0, axis +y, radius^2 and half
// height 1.0.
`default_nettype none
`include "ray_capped_cylinder_hit_test_top_defines.svh"
module ray_capped_cylinder_hit_test_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_origin_x,
  input  wire logic signed [31:0] in_origin_y,
  input  wire logic signed [31:0] in_origin_z,
  input  wire logic signed [17:0] in_dir_x,
  input  wire logic signed [17:0] in_dir_y,
  input  wire logic signed [17:0] in_dir_z,
  input  wire logic        [30:0] in_max_distance,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_hit,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [3:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);
  import rcc_pkg::*;

  rcc_cfg_t     cfg_r;
  rcc_item_t    f_item, q_head;
  rcc_fifo_st_t q_st;
  logic         f_item_v, q_push, q_pop, cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign q_push    = f_item_v && !q_st.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cx <= '0;
      cfg_r.cy <= '0;
      cfg_r.cz <= '0;
      cfg_r.ax <= '0;
      cfg_r.ay <= 18'sd65536;
      cfg_r.az <= '0;
      cfg_r.r2 <= 31'd65536;
      cfg_r.hh <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: cfg_r.cx <= cfg_data;
        CFG_CENTER_Y: cfg_r.cy <= cfg_data;
        CFG_CENTER_Z: cfg_r.cz <= cfg_data;
        CFG_AXIS_X:   cfg_r.ax <= cfg_data[17:0];
        CFG_AXIS_Y:   cfg_r.ay <= cfg_data[17:0];
        CFG_AXIS_Z:   cfg_r.az <= cfg_data[17:0];
        CFG_RADIUS2:  cfg_r.r2 <= cfg_data[30:0];
        CFG_HALF_H:   cfg_r.hh <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  rcc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_origin_z     (in_origin_z),
    .in_dir_x        (in_dir_x),
    .in_dir_y        (in_dir_y),
    .in_dir_z        (in_dir_z),
    .in_max_distance (in_max_distance),
    .q_full          (q_st.full),
    .item_v          (f_item_v),
    .item            (f_item)
  );

  rcc_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .push_d (f_item),
    .pop    (q_pop),
    .head_d (q_head),
    .st     (q_st)
  );

  rcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_v    (!q_st.empty),
    .head_d    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit)
  );

  `RCC_ASSERT_NOW(a_push_not_full, q_push, !q_st.full, "queue push while full")
  `RCC_ASSERT_NOW(a_pop_not_empty, q_pop, !q_st.empty, "queue pop while empty")
  `RCC_ASSERT_NEXT(a_cfg_r2_write, cfg_we && (cfg_index == CFG_RADIUS2),
                   cfg_r.r2 == $past(cfg_data[30:0]), "radius write lost")
endmodule
`default_nettype wire
